/* rtl/sfs_pkg.sv */
`default_nettype none

package sfs_pkg;

    // field and register widths
    localparam int SPR_W     = 12;
    localparam int RPM_W     = 10;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int COIL_W    = 4;
    localparam int STEPS_W   = 15;
    localparam int DELAY_W   = 16;

    localparam int MOVE_BITS_DEF = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_RPM     = 1'd1;

    localparam logic [SPR_W-1:0] SPR_RESET = 12'd200;
    localparam logic [RPM_W-1:0] RPM_RESET = 10'd1;

    // input op codes
    localparam logic OP_MOVE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [DELAY_W-1:0] MS_PER_MINUTE = 16'd60000;
    localparam int unsigned        MAX_MAG       = 32768;

    // full-step coil pattern for each phase
    function automatic logic [COIL_W-1:0] coil_of(input logic [1:0] phase);
        logic [COIL_W-1:0] c;
        case (phase)
            2'd0:    c = 4'b1010;
            2'd1:    c = 4'b0110;
            2'd2:    c = 4'b0101;
            2'd3:    c = 4'b1001;
            default: c = 4'b1010;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/sfs_delay_calc.sv */
`default_nettype none

module sfs_delay_calc (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sfs_pkg::SPR_W-1:0]    spr,
    input  logic [sfs_pkg::RPM_W-1:0]    rpm,
    output logic                         done,
    output logic [sfs_pkg::DELAY_W-1:0]  delay
);
    import sfs_pkg::*;

    localparam int PROD_W = SPR_W + RPM_W;
    localparam int CNT_W  = $clog2(DELAY_W);

    typedef enum logic [1:0] {C_IDLE, C_MUL, C_DIV, C_DONE} calc_state_t;

    calc_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;      // product, then remainder
    logic [PROD_W-1:0]   mcand_reg, mcand_next;  // multiplicand, then divisor
    logic [RPM_W-1:0]    mplier_reg, mplier_next;
    logic [DELAY_W-1:0]  quo_reg, quo_next;      // dividend shifts out, quotient in

    logic [PROD_W-1:0]   sum;
    logic [PROD_W:0]     trial;
    logic                fits;

    always_comb
    begin
        sum   = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
        trial = {acc_reg, quo_reg[DELAY_W-1]};
        fits  = (trial >= {1'b0, mcand_reg});

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        quo_next    = quo_reg;

        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    acc_next    = '0;
                    mcand_next  = {{RPM_W{1'b0}}, spr};
                    mplier_next = rpm;
                    cnt_next    = '0;
                    state_next  = C_MUL;
                end
            end
            C_MUL:
            begin
                // shift-add, one multiplier bit per cycle
                if (cnt_reg == CNT_W'(RPM_W - 1))
                begin
                    mcand_next = (sum == '0) ? PROD_W'(1) : sum;
                    acc_next   = '0;
                    quo_next   = MS_PER_MINUTE;
                    cnt_next   = '0;
                    state_next = C_DIV;
                end
                else
                begin
                    acc_next    = sum;
                    mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[RPM_W-1:1]};
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
            end
            C_DIV:
            begin
                // restoring division, one quotient bit per cycle
                acc_next = fits ? PROD_W'(trial - {1'b0, mcand_reg}) : trial[PROD_W-1:0];
                quo_next = {quo_reg[DELAY_W-2:0], fits};
                if (cnt_reg == CNT_W'(DELAY_W - 1))
                    state_next = C_DONE;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            C_DONE:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        quo_reg    <= quo_next;
    end

    assign done  = (state_reg == C_DONE);
    assign delay = (quo_reg == '0) ? DELAY_W'(1) : quo_reg;

endmodule

`default_nettype wire

/* rtl/stepper_full_step_sequencer_core.sv */
`default_nettype none

// four-wire full-step stepper sequencer. each input transaction is either a
// signed move command or one millisecond tick, and each gives exactly one
// result transaction with the coil drive, busy flag, steps still to go and an
// ignored flag for moves dropped while busy. the coils walk 1010, 0110, 0101,
// 1001 forward and the reverse order backward. a move takes its first step at
// once; every later step, and one final wait after the last, lasts
// 60000 / (steps_per_rev * speed_rpm) ticks, at least 1. the step delay is
// worked out afresh whenever a step is taken, by a bit-serial shift-add
// multiplier followed by a restoring divider, so a transaction that takes a
// step occupies the block longer than one that does not, and either is held
// further while the result side stalls and the previous result is still held.
// one transaction is in work at a time; a new one is taken while the previous
// result still waits in the output register. configuration writes are meant
// for idle periods only.
module stepper_full_step_sequencer_core #(
    parameter int MOVE_BITS = sfs_pkg::MOVE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration write port
    input  logic                          cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfs_pkg::CFG_W-1:0]     cfg_data,

    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic signed [MOVE_BITS-1:0]   move_steps,

    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sfs_pkg::COIL_W-1:0]    coils,
    output logic                          busy_res,
    output logic [sfs_pkg::STEPS_W-1:0]   steps_remaining,
    output logic                          ignored
);
    import sfs_pkg::*;

    // magnitude width: room for the most negative move and for the clamp value
    localparam int SAT_W = (MOVE_BITS + 1 > 17) ? MOVE_BITS + 1 : 17;

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_CALC, S_APPLY} seq_state_t;

    // configuration registers
    logic [SPR_W-1:0]      spr_reg;
    logic [RPM_W-1:0]      rpm_reg;

    // sequencer state
    seq_state_t            state_reg, state_next;
    logic [1:0]            phase_reg, phase_next;
    logic                  forward_reg, forward_next;
    logic [STEPS_W-1:0]    left_reg, left_next;
    logic [DELAY_W-1:0]    wait_reg, wait_next;
    logic                  active_reg, active_next;
    logic [COIL_W-1:0]     coil_reg, coil_next;

    // captured transaction and computed delay
    logic                  op_reg, op_next;
    logic [MOVE_BITS-1:0]  move_reg, move_next;
    logic [DELAY_W-1:0]    delay_reg, delay_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [COIL_W-1:0]     coils_reg, coils_next;
    logic                  busy_reg, busy_next;
    logic [STEPS_W-1:0]    steps_reg, steps_next;
    logic                  ignored_reg, ignored_next;

    // delay unit handshake
    logic                  calc_start;
    logic                  calc_done;
    logic [DELAY_W-1:0]    calc_delay;

    // decode of the captured transaction
    logic                  is_move;
    logic                  neg;
    logic [MOVE_BITS-1:0]  mag;
    logic [SAT_W-1:0]      mag_w;
    logic [SAT_W-1:0]      sat;
    logic [STEPS_W-1:0]    left_init;
    logic                  move_start;
    logic                  tick_run;
    logic [DELAY_W-1:0]    wait_dec;
    logic                  expire;
    logic                  tick_step;
    logic                  need_delay;
    logic                  out_free;
    logic                  in_take;

    sfs_delay_calc u_delay (
        .clk   (clk),
        .rst_n (rst_n),
        .start (calc_start),
        .spr   (spr_reg),
        .rpm   (rpm_reg),
        .done  (calc_done),
        .delay (calc_delay)
    );

    always_comb
    begin
        is_move    = (op_reg == OP_MOVE);
        neg        = move_reg[MOVE_BITS-1];
        mag        = neg ? (~move_reg + MOVE_BITS'(1)) : move_reg;
        mag_w      = {{(SAT_W - MOVE_BITS){1'b0}}, mag};
        // moves beyond the step counter range are clamped
        sat        = (mag_w > SAT_W'(MAX_MAG)) ? SAT_W'(MAX_MAG) : mag_w;
        left_init  = STEPS_W'(sat - SAT_W'(1));
        move_start = is_move && !active_reg && (mag != '0);

        // tick while running: count down, step or finish when the wait runs out
        tick_run   = (op_reg == OP_TICK) && active_reg;
        wait_dec   = (wait_reg != '0) ? (wait_reg - DELAY_W'(1)) : wait_reg;
        expire     = (wait_dec == '0);
        tick_step  = tick_run && expire && (left_reg != '0);
        need_delay = move_start || tick_step;

        out_free   = !out_valid_reg || !out_stall;
        in_take    = in_valid && (state_reg == S_IDLE);
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        forward_next   = forward_reg;
        left_next      = left_reg;
        wait_next      = wait_reg;
        active_next    = active_reg;
        coil_next      = coil_reg;
        op_next        = op_reg;
        move_next      = move_reg;
        delay_next     = delay_reg;
        out_valid_next = out_valid_reg && out_stall;
        coils_next     = coils_reg;
        busy_next      = busy_reg;
        steps_next     = steps_reg;
        ignored_next   = ignored_reg;
        calc_start     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next    = op;
                    move_next  = move_steps;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (need_delay)
                begin
                    calc_start = 1'b1;
                    state_next = S_CALC;
                end
                else
                begin
                    state_next = S_APPLY;
                end
            end
            S_CALC:
            begin
                if (calc_done)
                begin
                    delay_next = calc_delay;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                // commit only once the output register can take the result
                if (out_free)
                begin
                    if (move_start)
                    begin
                        forward_next = !neg;
                        left_next    = left_init;
                        active_next  = 1'b1;
                        phase_next   = neg ? (phase_reg - 2'd1) : (phase_reg + 2'd1);
                        wait_next    = delay_reg;
                    end
                    else if (tick_run)
                    begin
                        wait_next = wait_dec;
                        if (expire)
                        begin
                            if (left_reg != '0)
                            begin
                                left_next  = left_reg - STEPS_W'(1);
                                phase_next = forward_reg ? (phase_reg + 2'd1)
                                                         : (phase_reg - 2'd1);
                                wait_next  = delay_reg;
                            end
                            else
                            begin
                                active_next = 1'b0;
                            end
                        end
                    end

                    if (need_delay)
                        coil_next = coil_of(phase_next);

                    out_valid_next = 1'b1;
                    coils_next     = need_delay ? coil_of(phase_next) : coil_reg;
                    busy_next      = active_next;
                    steps_next     = left_next;
                    ignored_next   = is_move && active_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg       <= SPR_RESET;
            rpm_reg       <= RPM_RESET;
            state_reg     <= S_IDLE;
            phase_reg     <= 2'd0;
            forward_reg   <= 1'b0;
            left_reg      <= '0;
            wait_reg      <= '0;
            active_reg    <= 1'b0;
            coil_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_STEPS_PER_REV))
                spr_reg <= cfg_data[SPR_W-1:0];
            if (cfg_we && (cfg_index == REG_SPEED_RPM))
                rpm_reg <= cfg_data[RPM_W-1:0];
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            forward_reg   <= forward_next;
            left_reg      <= left_next;
            wait_reg      <= wait_next;
            active_reg    <= active_next;
            coil_reg      <= coil_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        move_reg    <= move_next;
        delay_reg   <= delay_next;
        coils_reg   <= coils_next;
        busy_reg    <= busy_next;
        steps_reg   <= steps_next;
        ignored_reg <= ignored_next;
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign coils           = coils_reg;
    assign busy_res        = busy_reg;
    assign steps_remaining = steps_reg;
    assign ignored         = ignored_reg;

endmodule

`default_nettype wire
